// File: sv/css_pkg.sv
// Shared types and constants of the contingency skill score block.
package css_pkg;

  // Fixed widths of the result, threshold, index and selector fields
  localparam int unsigned CNT_OUT_W = 24;
  localparam int unsigned SCORE_OUT_W = 16;
  localparam int unsigned THR_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SEL_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FCST_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC = 2'd2;

  // Score selector codes
  localparam logic [SEL_W-1:0] MET_ETS = 3'd0;
  localparam logic [SEL_W-1:0] MET_TS = 3'd1;
  localparam logic [SEL_W-1:0] MET_PC = 3'd2;
  localparam logic [SEL_W-1:0] MET_KSS = 3'd3;
  localparam logic [SEL_W-1:0] MET_BIAS = 3'd4;
  localparam logic [SEL_W-1:0] MET_HSS = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MLOAD,
    S_MRUN,
    S_FORM,
    S_DIFF,
    S_DLOAD,
    S_DRUN,
    S_FIN,
    S_REPORT
  } css_state_t;

  typedef struct packed {
    logic       count;
    logic       last;
    logic       mload;
    logic       mstep;
    logic [1:0] prod_idx;
    logic       form;
    logic       diff;
    logic       dload;
    logic       dstep;
    logic       finish;
  } css_cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       div_done;
    logic [2:0] nprod;
  } css_stat_t;

  // Number of products a score needs
  function automatic logic [2:0] num_products(logic [SEL_W-1:0] sel);
    logic [2:0] n;
    case (sel)
      MET_ETS: n = 3'd3;
      MET_KSS: n = 3'd3;
      MET_HSS: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: sv/css_ctrl.sv
// Sequencer that steps the datapath through counting, products and division.
module css_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_pair,
  input  css_pkg::css_stat_t stat,
  output css_pkg::css_cmd_t  cmd,
  output logic              busy,
  output logic              done
);

  css_pkg::css_state_t state, state_next;
  logic [1:0] idx, idx_next;

  // State and product index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= css_pkg::S_IDLE;
      idx <= 2'd0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.prod_idx = idx;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      css_pkg::S_IDLE: begin
        busy = 1'b0;
        idx_next = 2'd0;
        if (start) begin
          cmd.count = 1'b1;
          cmd.last = last_pair;
          if (last_pair) begin
            state_next = (stat.nprod != 3'd0) ? css_pkg::S_MLOAD : css_pkg::S_FORM;
          end
        end
      end
      css_pkg::S_MLOAD: begin
        cmd.mload = 1'b1;
        state_next = css_pkg::S_MRUN;
      end
      css_pkg::S_MRUN: begin
        cmd.mstep = 1'b1;
        if (stat.mul_done) begin
          if ({1'b0, idx} == stat.nprod - 3'd1) begin
            state_next = css_pkg::S_FORM;
          end else begin
            idx_next = idx + 2'd1;
            state_next = css_pkg::S_MLOAD;
          end
        end
      end
      css_pkg::S_FORM: begin
        cmd.form = 1'b1;
        state_next = css_pkg::S_DIFF;
      end
      css_pkg::S_DIFF: begin
        cmd.diff = 1'b1;
        state_next = css_pkg::S_DLOAD;
      end
      css_pkg::S_DLOAD: begin
        cmd.dload = 1'b1;
        state_next = css_pkg::S_DRUN;
      end
      css_pkg::S_DRUN: begin
        cmd.dstep = 1'b1;
        if (stat.div_done) begin
          state_next = css_pkg::S_FIN;
        end
      end
      css_pkg::S_FIN: begin
        cmd.finish = 1'b1;
        state_next = css_pkg::S_REPORT;
      end
      css_pkg::S_REPORT: begin
        done = 1'b1;
        state_next = css_pkg::S_IDLE;
      end
      default: begin
        state_next = css_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/css_datapath.sv
// Counters, shift-add multiplier, restoring divider and result registers.
module css_datapath #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned SCORE_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  css_pkg::css_cmd_t                      cmd,
  output css_pkg::css_stat_t                     stat,
  input  logic                                   cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [css_pkg::THR_W-1:0]              cfg_data,
  input  logic signed [css_pkg::THR_W-1:0]       ref_value,
  input  logic signed [css_pkg::THR_W-1:0]       fcst_value,
  output logic signed [css_pkg::SCORE_OUT_W-1:0] skill_score,
  output logic                                   score_valid,
  output logic [css_pkg::CNT_OUT_W-1:0]          hits,
  output logic [css_pkg::CNT_OUT_W-1:0]          false_alarms,
  output logic [css_pkg::CNT_OUT_W-1:0]          misses,
  output logic [css_pkg::CNT_OUT_W-1:0]          correct_negatives
);

  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned F = SCORE_FRAC_BITS;
  localparam int unsigned M = CW + 2;
  localparam int unsigned W = 2 * CW + 5;
  localparam int unsigned MCW = $clog2(M);
  localparam int unsigned DCW = $clog2(F + 1);
  localparam int unsigned OW = css_pkg::CNT_OUT_W;
  localparam int unsigned SOW = css_pkg::SCORE_OUT_W;
  localparam int unsigned SW = (F + 2 > SOW) ? F + 2 : SOW;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [MCW-1:0] MCNT_LAST = MCW'(M - 1);
  localparam logic [DCW-1:0] DCNT_LAST = DCW'(F);

  logic signed [css_pkg::THR_W-1:0] ref_thr, fcst_thr;
  logic [css_pkg::SEL_W-1:0] metric;
  logic [CW-1:0] cnt_a, cnt_b, cnt_c, cnt_d;
  logic [CW-1:0] a_next, b_next, c_next, d_next;
  logic [CW-1:0] sa, sb, sc, sd;
  logic ref_ev, fc_ev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_thr <= '0;
      fcst_thr <= '0;
      metric <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        css_pkg::REG_REF_THR: ref_thr <= cfg_data;
        css_pkg::REG_FCST_THR: fcst_thr <= cfg_data;
        css_pkg::REG_METRIC: metric <= cfg_data[css_pkg::SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the beat and bump the matching counter, saturating
  always_comb begin
    ref_ev = ref_value > ref_thr;
    fc_ev = fcst_value > fcst_thr;
    a_next = cnt_a;
    b_next = cnt_b;
    c_next = cnt_c;
    d_next = cnt_d;
    if (ref_ev && fc_ev) begin
      if (cnt_a != CNT_MAX) a_next = cnt_a + 1'b1;
    end else if (fc_ev) begin
      if (cnt_b != CNT_MAX) b_next = cnt_b + 1'b1;
    end else if (ref_ev) begin
      if (cnt_c != CNT_MAX) c_next = cnt_c + 1'b1;
    end else begin
      if (cnt_d != CNT_MAX) d_next = cnt_d + 1'b1;
    end
  end

  // Running counters; snapshot and clear on the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      cnt_c <= '0;
      cnt_d <= '0;
    end else if (cmd.count) begin
      if (cmd.last) begin
        cnt_a <= '0;
        cnt_b <= '0;
        cnt_c <= '0;
        cnt_d <= '0;
      end else begin
        cnt_a <= a_next;
        cnt_b <= b_next;
        cnt_c <= c_next;
        cnt_d <= d_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count && cmd.last) begin
      sa <= a_next;
      sb <= b_next;
      sc <= c_next;
      sd <= d_next;
    end
  end

  // Sums of the snapshot
  logic [M-1:0] ea, eb, ec, ed, s_ab, s_ac, s_bd, s_cd, s_bc, s_abc, s_ad, s_n, min2;
  always_comb begin
    ea = M'(sa);
    eb = M'(sb);
    ec = M'(sc);
    ed = M'(sd);
    s_ab = ea + eb;
    s_ac = ea + ec;
    s_bd = eb + ed;
    s_cd = ec + ed;
    s_bc = eb + ec;
    s_ad = ea + ed;
    s_abc = s_ab + ec;
    s_n = s_ab + s_cd;
    min2 = ((sb < sc) ? eb : ec) << 1;
  end

  // Select multiplier operands for the current product
  logic [M-1:0] op_x, op_y;
  always_comb begin
    op_x = '0;
    op_y = '0;
    case (metric)
      css_pkg::MET_ETS: begin
        case (cmd.prod_idx)
          2'd0: begin op_x = s_ab; op_y = s_ac; end
          2'd1: begin op_x = ea; op_y = s_n; end
          default: begin op_x = s_abc; op_y = s_n; end
        endcase
      end
      css_pkg::MET_KSS: begin
        case (cmd.prod_idx)
          2'd0: begin op_x = ea; op_y = ed; end
          2'd1: begin op_x = eb; op_y = ec; end
          default: begin op_x = s_ac; op_y = s_bd; end
        endcase
      end
      css_pkg::MET_HSS: begin
        case (cmd.prod_idx)
          2'd0: begin op_x = ea; op_y = ed; end
          2'd1: begin op_x = eb; op_y = ec; end
          2'd2: begin op_x = s_ac; op_y = s_cd; end
          default: begin op_x = s_ab; op_y = s_bd; end
        endcase
      end
      default: ;
    endcase
  end

  // Shift-add multiplier, one multiplier bit per cycle
  logic [W-1:0] mcand, acc, acc_next;
  logic [M-1:0] mplier;
  logic [MCW-1:0] mcnt;
  logic [W-1:0] prod [4];

  assign acc_next = mplier[0] ? acc + mcand : acc;

  always_ff @(posedge clk) begin
    if (cmd.mload) begin
      mcand <= W'(op_x);
      mplier <= op_y;
      acc <= '0;
      mcnt <= '0;
    end else if (cmd.mstep) begin
      acc <= acc_next;
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      mcnt <= mcnt + 1'b1;
      if (mcnt == MCNT_LAST) prod[cmd.prod_idx] <= acc_next;
    end
  end

  // Form numerator parts and denominator
  logic [W-1:0] pos_c, neg_c, den_c, pos, neg, den;
  logic ok_c, ok;
  always_comb begin
    pos_c = '0;
    neg_c = '0;
    den_c = '0;
    ok_c = 1'b1;
    case (metric)
      css_pkg::MET_ETS: begin
        pos_c = prod[1];
        neg_c = prod[0];
        den_c = prod[2] - prod[0];
      end
      css_pkg::MET_TS: begin
        pos_c = W'(ea);
        den_c = W'(s_abc);
      end
      css_pkg::MET_PC: begin
        pos_c = W'(s_ad);
        den_c = W'(s_n);
      end
      css_pkg::MET_KSS: begin
        pos_c = prod[0];
        neg_c = prod[1];
        den_c = prod[2];
      end
      css_pkg::MET_BIAS: begin
        pos_c = W'(min2);
        den_c = W'(s_bc);
      end
      css_pkg::MET_HSS: begin
        pos_c = prod[0] << 1;
        neg_c = prod[1] << 1;
        den_c = prod[2] + prod[3];
      end
      default: ok_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      pos <= pos_c;
      neg <= neg_c;
      den <= den_c;
      ok <= ok_c && (den_c != '0);
    end
  end

  // Magnitude and sign of the numerator
  logic [W-1:0] mag;
  logic is_neg;
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      is_neg <= pos < neg;
      mag <= (pos < neg) ? neg - pos : pos - neg;
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [W-1:0] rem;
  logic [W:0] rem2;
  logic [F:0] quo;
  logic [DCW-1:0] dcnt;
  logic sat;
  logic take;

  assign rem2 = {rem, 1'b0};
  assign take = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.dload) begin
      sat <= mag >= den;
      rem <= mag;
      quo <= '0;
      dcnt <= '0;
    end else if (cmd.dstep) begin
      rem <= take ? W'(rem2 - {1'b0, den}) : W'(rem2);
      quo <= {quo[F-1:0], take};
      dcnt <= dcnt + 1'b1;
    end
  end

  // Round, saturate, sign and hold the result
  logic [F+1:0] rnd;
  logic [F:0] mag_q;
  logic signed [SW-1:0] score_w;
  logic signed [SOW-1:0] score_q;
  logic valid_q;

  always_comb begin
    rnd = ({1'b0, quo} + 1'b1) >> 1;
    mag_q = sat ? (F+1)'(1) << F : rnd[F:0];
    score_w = is_neg ? -$signed(SW'(mag_q)) : $signed(SW'(mag_q));
    if (!ok) score_w = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      score_q <= score_w[SOW-1:0];
      valid_q <= ok;
    end
  end

  assign skill_score = score_q;
  assign score_valid = valid_q;
  assign hits = OW'(sa);
  assign false_alarms = OW'(sb);
  assign misses = OW'(sc);
  assign correct_negatives = OW'(sd);

  // Status back to the sequencer
  assign stat.mul_done = (mcnt == MCNT_LAST);
  assign stat.div_done = (dcnt == DCNT_LAST);
  assign stat.nprod = css_pkg::num_products(metric);

endmodule

// File: sv/contingency_skill_score_top.sv
// Contingency table skill score: top level joining sequencer and datapath.
//
// Pairs enter on start while busy is low; each is classed against the two
// thresholds and counted (saturating) in the cycle it is taken. A pair that
// is not marked last leaves busy low, so pairs may enter every cycle.
// A pair marked last raises busy; the block then works out the selected
// score and pulses done for one cycle with the score, its valid flag and
// the four counts of the set. The counters clear for the next set.
// The score needs P products (3 for ETS and KSS, 4 for HSS, 0 otherwise)
// from the shift-add multiplier (one bit a cycle), then a quotient from
// the restoring divider (one quotient bit a cycle).
// The receiver cannot stall: done lasts one cycle and must be taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the
// user must make them only while busy is low, which the block does not
// enforce. Reset clears counters, thresholds, selector.
module contingency_skill_score_top #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned SCORE_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  output logic                                   done,
  input  logic                                   cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [css_pkg::THR_W-1:0]              cfg_data,
  input  logic signed [css_pkg::THR_W-1:0]       ref_value,
  input  logic signed [css_pkg::THR_W-1:0]       fcst_value,
  input  logic                                   last_pair,
  output logic signed [css_pkg::SCORE_OUT_W-1:0] skill_score,
  output logic                                   score_valid,
  output logic [css_pkg::CNT_OUT_W-1:0]          hits,
  output logic [css_pkg::CNT_OUT_W-1:0]          false_alarms,
  output logic [css_pkg::CNT_OUT_W-1:0]          misses,
  output logic [css_pkg::CNT_OUT_W-1:0]          correct_negatives
);

  css_pkg::css_cmd_t cmd;
  css_pkg::css_stat_t stat;

  css_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_pair (last_pair),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  css_datapath #(
    .COUNT_BITS      (COUNT_BITS),
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ref_value         (ref_value),
    .fcst_value        (fcst_value),
    .skill_score       (skill_score),
    .score_valid       (score_valid),
    .hits              (hits),
    .false_alarms      (false_alarms),
    .misses            (misses),
    .correct_negatives (correct_negatives)
  );

  // A result beat only comes out of a busy block
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // A pair without the last mark keeps the block free
  a_plain_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_pair) |=> !busy)
    else $error("busy after unmarked pair");

  // The last pair starts the score work
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_pair) |=> busy)
    else $error("no work after last pair");

  // An invalid score reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !score_valid) |-> (skill_score == '0))
    else $error("nonzero invalid score");

  // One result beat per set
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");

endmodule
